// ----- hw/rtl/lap_stopwatch_core_assert.svh -----
// ----------------------------------------------------------------------------
// lap_stopwatch_core_assert.svh
// Assertion macros for the stopwatch core RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LAP_STOPWATCH_CORE_ASSERT_SVH
`define LAP_STOPWATCH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LSW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LSW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define LSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/lsw_pkg.sv -----
// ----------------------------------------------------------------------------
// lsw_pkg
// Shared codes, widths, reciprocal constants and the result record type.
// ----------------------------------------------------------------------------
`default_nettype none
package lsw_pkg;

	// input word kinds
	localparam logic [1:0] MODE_TIME      = 2'd0;
	localparam logic [1:0] MODE_PRIMARY   = 2'd1;
	localparam logic [1:0] MODE_SECONDARY = 2'd2;

	// run state codes on the result port
	localparam logic [1:0] RS_IDLE = 2'd0;
	localparam logic [1:0] RS_RUN  = 2'd1;
	localparam logic [1:0] RS_STOP = 2'd2;

	localparam int LAP_SLOTS = 3;
	localparam int LAP_CNT_W = 2;
	localparam int TIME_W    = 32;
	localparam int LAPNUM_W  = 16;

	// widths of the split of elapsed time
	localparam int CS_W    = 29;	// elapsed / 10
	localparam int Q100_W  = 23;	// elapsed / 1000
	localparam int MIN_W   = 17;
	localparam int SEC_W   = 6;
	localparam int CENTI_W = 7;

	// reciprocals: x/10 = (x*R10)>>35, x/100 = (x*R100)>>37, x/60 = (x*R60)>>29
	localparam logic [31:0] RECIP_10  = 32'hCCCC_CCCD;
	localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
	localparam logic [23:0] RECIP_60  = 24'd8947849;
	localparam int CENTI_PER_SEC = 100;
	localparam int SEC_PER_MIN   = 60;

	// stopwatch view after one word
	typedef struct packed {
		logic [1:0]                          run_state;
		logic [TIME_W-1:0]                   elapsed_ms;
		logic [LAP_CNT_W-1:0]                laps_shown;
		logic [LAP_SLOTS-1:0][TIME_W-1:0]    lap_ms;
		logic [LAP_SLOTS-1:0][LAPNUM_W-1:0]  lap_num;
	} view_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lsw_state.sv -----
// ----------------------------------------------------------------------------
// lsw_state
// Stopwatch state machine and lap memory; presents the view after each word.
// ----------------------------------------------------------------------------
`default_nettype none
module lsw_state (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 take,
	input  wire logic [1:0]           mode,
	input  wire logic [31:0]          now_ms,
	output lsw_pkg::view_t            view
);

	typedef enum logic [1:0] {
		PH_IDLE = lsw_pkg::RS_IDLE,
		PH_RUN  = lsw_pkg::RS_RUN,
		PH_STOP = lsw_pkg::RS_STOP
	} phase_t;

	localparam int TW = lsw_pkg::TIME_W;
	localparam int NW = lsw_pkg::LAPNUM_W;
	localparam int LS = lsw_pkg::LAP_SLOTS;
	localparam int CW = lsw_pkg::LAP_CNT_W;

	phase_t                 phase_q, phase_n;
	logic [TW-1:0]          cur_q, cur_n;
	logic [TW-1:0]          acc_q, acc_n;
	logic [TW-1:0]          seg_q, seg_n;
	logic [CW-1:0]          valid_q, valid_n;
	logic [NW-1:0]          total_q, total_n;
	logic [LS-1:0][TW-1:0]  lap_ms_q, lap_ms_n;
	logic [LS-1:0][NW-1:0]  lap_num_q, lap_num_n;
	logic [TW-1:0]          elapsed_now;
	logic                   clear;

	// elapsed time as the state stands before this word
	assign elapsed_now = acc_q + ((phase_q == PH_RUN) ? (cur_q - seg_q) : '0);

	// next state
	always_comb begin
		phase_n   = phase_q;
		cur_n     = cur_q;
		acc_n     = acc_q;
		seg_n     = seg_q;
		valid_n   = valid_q;
		total_n   = total_q;
		lap_ms_n  = lap_ms_q;
		lap_num_n = lap_num_q;
		clear     = 1'b0;
		unique case (mode)
			lsw_pkg::MODE_TIME: begin
				cur_n = now_ms;
			end
			lsw_pkg::MODE_PRIMARY: begin
				unique case (phase_q)
					PH_IDLE: begin
						seg_n   = cur_q;
						phase_n = PH_RUN;
					end
					PH_RUN: begin
						// record a lap, newest in slot 0
						total_n   = total_q + NW'(1);
						lap_ms_n  = {lap_ms_q[LS-2:0], elapsed_now};
						lap_num_n = {lap_num_q[LS-2:0], total_n};
						if (valid_q != CW'(LS)) begin
							valid_n = valid_q + CW'(1);
						end
					end
					default: begin
						clear = 1'b1;
					end
				endcase
			end
			lsw_pkg::MODE_SECONDARY: begin
				unique case (phase_q)
					PH_RUN: begin
						acc_n   = acc_q + (cur_q - seg_q);
						phase_n = PH_STOP;
					end
					PH_STOP: begin
						seg_n   = cur_q;
						phase_n = PH_RUN;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
		// full reset from stopped; lap slots are hidden by the count
		if (clear) begin
			phase_n = PH_IDLE;
			cur_n   = '0;
			acc_n   = '0;
			seg_n   = '0;
			valid_n = '0;
			total_n = '0;
		end
	end

	// view after this word
	always_comb begin
		view.run_state  = phase_n;
		view.elapsed_ms = acc_n + ((phase_n == PH_RUN) ? (cur_n - seg_n) : '0);
		view.laps_shown = valid_n;
		for (int k = 0; k < LS; k++) begin
			view.lap_ms[k]  = (valid_n > CW'(k)) ? lap_ms_n[k] : '0;
			view.lap_num[k] = (valid_n > CW'(k)) ? lap_num_n[k] : '0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cur_q   <= '0;
			acc_q   <= '0;
			seg_q   <= '0;
			valid_q <= '0;
			total_q <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			cur_q   <= cur_n;
			acc_q   <= acc_n;
			seg_q   <= seg_n;
			valid_q <= valid_n;
			total_q <= total_n;
		end
	end

	// lap slots carry no reset
	always_ff @(posedge clk) begin
		if (take) begin
			lap_ms_q  <= lap_ms_n;
			lap_num_q <= lap_num_n;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lap_stopwatch_core.sv -----
// ----------------------------------------------------------------------------
// lap_stopwatch_core
// Three-state lap stopwatch with a five-stage result pipeline that splits
// elapsed time into minutes, seconds and centiseconds.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | in_valid / in_ready  | mode, now_ms
//   out     | out_valid / out_ready| run_state, elapsed_ms, minutes, seconds,
//           |                      | centiseconds, laps_shown, lapK_ms/number
//
// One word per cycle sustained while out_ready stays high; once taken, each
// word passes state update, /10, /100, /60 and the two remainders in turn.
// State updates at the accepting edge, so the next word sees it at once.
// Each stage holds while the stage after it is full and stalled; in_ready
// stays high while any stage ahead has a bubble.
// Reset clears the stopwatch state apart from the lap slots, and all stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lap_stopwatch_core_assert.svh"
module lap_stopwatch_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       run_state,
	output logic [31:0]      elapsed_ms,
	output logic [16:0]      minutes,
	output logic [5:0]       seconds,
	output logic [6:0]       centiseconds,
	output logic [1:0]       laps_shown,
	output logic [31:0]      lap0_ms,
	output logic [15:0]      lap0_number,
	output logic [31:0]      lap1_ms,
	output logic [15:0]      lap1_number,
	output logic [31:0]      lap2_ms,
	output logic [15:0]      lap2_number
);

	localparam int CSW = lsw_pkg::CS_W;
	localparam int QW  = lsw_pkg::Q100_W;
	localparam int MW  = lsw_pkg::MIN_W;

	lsw_pkg::view_t   view_n;
	lsw_pkg::view_t   view_s1, view_s2, view_s3, view_s4, view_s5;
	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	logic             rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic             take;

	logic [CSW-1:0]   cs_s2, cs_s3;
	logic [QW-1:0]    q100_s3, q100_s4;
	logic [MW-1:0]    min_s4, min_s5;
	logic [6:0]       centi_s4, centi_s5;
	logic [5:0]       sec_s5;

	logic [63:0]      cs_prod;
	logic [63:0]      q100_prod;
	logic [47:0]      min_prod;
	logic [CSW-1:0]   centi_rem;
	logic [QW-1:0]    sec_rem;

	// stage flow control
	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign take     = in_valid && rdy_s1;

	lsw_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.mode   (mode),
		.now_ms (now_ms),
		.view   (view_n)
	);

	// time split arithmetic
	assign cs_prod   = {32'd0, view_s1.elapsed_ms} * {32'd0, lsw_pkg::RECIP_10};
	assign q100_prod = {35'd0, cs_s2} * {32'd0, lsw_pkg::RECIP_100};
	assign min_prod  = {25'd0, q100_s3} * {24'd0, lsw_pkg::RECIP_60};
	assign centi_rem = cs_s3 - (CSW'(q100_s3) * CSW'(lsw_pkg::CENTI_PER_SEC));
	assign sec_rem   = q100_s4 - (QW'(min_s4) * QW'(lsw_pkg::SEC_PER_MIN));

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			view_s1 <= view_n;
		end
		if (rdy_s2 && v_s1) begin
			view_s2 <= view_s1;
			cs_s2   <= cs_prod[63:35];
		end
		if (rdy_s3 && v_s2) begin
			view_s3 <= view_s2;
			cs_s3   <= cs_s2;
			q100_s3 <= q100_prod[59:37];
		end
		if (rdy_s4 && v_s3) begin
			view_s4  <= view_s3;
			q100_s4  <= q100_s3;
			min_s4   <= min_prod[45:29];
			centi_s4 <= centi_rem[6:0];
		end
		if (rdy_s5 && v_s4) begin
			view_s5  <= view_s4;
			min_s5   <= min_s4;
			centi_s5 <= centi_s4;
			sec_s5   <= sec_rem[5:0];
		end
	end

	// result ports
	assign out_valid    = v_s5;
	assign run_state    = view_s5.run_state;
	assign elapsed_ms   = view_s5.elapsed_ms;
	assign minutes      = min_s5;
	assign seconds      = sec_s5;
	assign centiseconds = centi_s5;
	assign laps_shown   = view_s5.laps_shown;
	assign lap0_ms      = view_s5.lap_ms[0];
	assign lap0_number  = view_s5.lap_num[0];
	assign lap1_ms      = view_s5.lap_ms[1];
	assign lap1_number  = view_s5.lap_num[1];
	assign lap2_ms      = view_s5.lap_ms[2];
	assign lap2_number  = view_s5.lap_num[2];

	// checks
	`LSW_ASSERT_SAME(a_split_range, clk, arst_n, out_valid, centiseconds < 7'd100 && seconds < 6'd60, "time split out of range")
	`LSW_ASSERT_SAME(a_idle_zero, clk, arst_n, out_valid && run_state == lsw_pkg::RS_IDLE, elapsed_ms == 32'd0 && laps_shown == 2'd0, "idle result not cleared")
	`LSW_ASSERT_SAME(a_hidden_lap, clk, arst_n, out_valid && laps_shown == 2'd0, lap0_ms == 32'd0 && lap0_number == 16'd0, "hidden lap slot not zero")
	`LSW_ASSERT_NEXT(a_take_fills, clk, arst_n, take, v_s1, "taken word missing in first stage")

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: lap stopwatch core testbench
// Drives time, primary, secondary and unused words into the stopwatch with
// random gaps on both channels. A scoreboard tracks its own copy of the
// stopwatch state and checks every result view field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// mode code the block must ignore
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// one result view as seen on the output port
	typedef struct packed {
		logic [1:0]                                         run_state;
		logic [lsw_pkg::TIME_W-1:0]                         elapsed_ms;
		logic [lsw_pkg::MIN_W-1:0]                          minutes;
		logic [lsw_pkg::SEC_W-1:0]                          seconds;
		logic [lsw_pkg::CENTI_W-1:0]                        centiseconds;
		logic [lsw_pkg::LAP_CNT_W-1:0]                      laps_shown;
		logic [lsw_pkg::LAP_SLOTS-1:0][lsw_pkg::TIME_W-1:0]   lap_ms;
		logic [lsw_pkg::LAP_SLOTS-1:0][lsw_pkg::LAPNUM_W-1:0] lap_num;
	} watch_view_t;

	// Scoreboard: mirrors the stopwatch and keeps the views still owed
	class stopwatch_tracker;
		logic [1:0]                                         phase;
		logic [lsw_pkg::TIME_W-1:0]                         cur_time;
		logic [lsw_pkg::TIME_W-1:0]                         accum;
		logic [lsw_pkg::TIME_W-1:0]                         seg_start;
		logic [lsw_pkg::LAP_CNT_W-1:0]                      laps_valid;
		logic [lsw_pkg::LAPNUM_W-1:0]                       lap_count;
		logic [lsw_pkg::LAP_SLOTS-1:0][lsw_pkg::TIME_W-1:0]   lap_times;
		logic [lsw_pkg::LAP_SLOTS-1:0][lsw_pkg::LAPNUM_W-1:0] lap_nums;
		watch_view_t                                        pending_views[$];
		int unsigned                                        mismatches;
		int unsigned                                        words;
		int unsigned                                        views_checked;

		function new();
			clear_watch();
			mismatches    = 0;
			words         = 0;
			views_checked = 0;
		endfunction

		function void clear_watch();
			phase      = lsw_pkg::RS_IDLE;
			cur_time   = '0;
			accum      = '0;
			seg_start  = '0;
			laps_valid = '0;
			lap_count  = '0;
			lap_times  = '0;
			lap_nums   = '0;
		endfunction

		// all arithmetic wraps at 32 bits
		function logic [lsw_pkg::TIME_W-1:0] elapsed_now();
			logic [lsw_pkg::TIME_W-1:0] run_part;
			run_part = (phase == lsw_pkg::RS_RUN) ? cur_time - seg_start : '0;
			return accum + run_part;
		endfunction

		// note an accepted input word and queue the view it must produce
		function void take_word(logic [1:0] m, logic [lsw_pkg::TIME_W-1:0] t);
			watch_view_t                v;
			logic [lsw_pkg::TIME_W-1:0] e;
			logic [lsw_pkg::TIME_W-1:0] cs;
			logic [31:0]                q_min;
			logic [31:0]                q_sec;
			logic [31:0]                q_centi;
			words++;
			case (m)
				lsw_pkg::MODE_TIME: cur_time = t;
				lsw_pkg::MODE_PRIMARY: begin
					case (phase)
						lsw_pkg::RS_IDLE: begin
							seg_start = cur_time;
							phase     = lsw_pkg::RS_RUN;
						end
						lsw_pkg::RS_RUN: begin
							lap_times = {lap_times[1:0], elapsed_now()};
							lap_count = lap_count + lsw_pkg::LAPNUM_W'(1);
							lap_nums  = {lap_nums[1:0], lap_count};
							if (laps_valid < lsw_pkg::LAP_SLOTS)
								laps_valid++;
						end
						default: clear_watch();	// full reset from stopped
					endcase
				end
				lsw_pkg::MODE_SECONDARY: begin
					if (phase == lsw_pkg::RS_RUN) begin
						accum = accum + (cur_time - seg_start);
						phase = lsw_pkg::RS_STOP;
					end else if (phase == lsw_pkg::RS_STOP) begin
						seg_start = cur_time;
						phase     = lsw_pkg::RS_RUN;
					end
				end
				default: ;	// unused mode leaves state alone
			endcase

			e       = elapsed_now();
			cs      = e / 10;
			q_min   = cs / 6000;
			q_sec   = (cs / 100) % 60;
			q_centi = cs % 100;
			v.run_state    = phase;
			v.elapsed_ms   = e;
			v.minutes      = q_min[lsw_pkg::MIN_W-1:0];
			v.seconds      = q_sec[lsw_pkg::SEC_W-1:0];
			v.centiseconds = q_centi[lsw_pkg::CENTI_W-1:0];
			v.laps_shown   = laps_valid;
			for (int k = 0; k < lsw_pkg::LAP_SLOTS; k++) begin
				v.lap_ms[k]  = (k < laps_valid) ? lap_times[k] : '0;
				v.lap_num[k] = (k < laps_valid) ? lap_nums[k] : '0;
			end
			pending_views.push_back(v);
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			mismatches++;
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
				$realtime, field, got, want);
		endtask

		// compare one accepted result with the oldest pending view
		task match_view(watch_view_t got);
			watch_view_t want;
			if (pending_views.size() == 0) begin
				report("result with nothing pending (elapsed_ms)", got.elapsed_ms, '0);
				return;
			end
			want = pending_views.pop_front();
			views_checked++;
			if (got.run_state != want.run_state)
				report("run_state", 32'(got.run_state), 32'(want.run_state));
			if (got.elapsed_ms != want.elapsed_ms)
				report("elapsed_ms", got.elapsed_ms, want.elapsed_ms);
			if (got.minutes != want.minutes)
				report("minutes", 32'(got.minutes), 32'(want.minutes));
			if (got.seconds != want.seconds)
				report("seconds", 32'(got.seconds), 32'(want.seconds));
			if (got.centiseconds != want.centiseconds)
				report("centiseconds", 32'(got.centiseconds), 32'(want.centiseconds));
			if (got.laps_shown != want.laps_shown)
				report("laps_shown", 32'(got.laps_shown), 32'(want.laps_shown));
			for (int k = 0; k < lsw_pkg::LAP_SLOTS; k++) begin
				if (got.lap_ms[k] != want.lap_ms[k])
					report($sformatf("lap%0d_ms", k), got.lap_ms[k], want.lap_ms[k]);
				if (got.lap_num[k] != want.lap_num[k])
					report($sformatf("lap%0d_number", k), 32'(got.lap_num[k]),
						32'(want.lap_num[k]));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  run_state;
	logic [31:0] elapsed_ms;
	logic [16:0] minutes;
	logic [5:0]  seconds;
	logic [6:0]  centiseconds;
	logic [1:0]  laps_shown;
	logic [31:0] lap0_ms;
	logic [15:0] lap0_number;
	logic [31:0] lap1_ms;
	logic [15:0] lap1_number;
	logic [31:0] lap2_ms;
	logic [15:0] lap2_number;

	stopwatch_tracker tracker = new();

	int          send_idle_pct = 23;
	int          recv_idle_pct = 84;
	int          hold_left     = 0;
	logic [31:0] clock_ms      = '0;

	lap_stopwatch_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.run_state    (run_state),
		.elapsed_ms   (elapsed_ms),
		.minutes      (minutes),
		.seconds      (seconds),
		.centiseconds (centiseconds),
		.laps_shown   (laps_shown),
		.lap0_ms      (lap0_ms),
		.lap0_number  (lap0_number),
		.lap1_ms      (lap1_ms),
		.lap1_number  (lap1_number),
		.lap2_ms      (lap2_ms),
		.lap2_number  (lap2_number)
	);

	always #4 clk = ~clk;

	// offer one word, with random gaps ahead of it, and wait until taken
	task automatic send_word(input logic [1:0] m, input logic [31:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		now_ms   <= t;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_word(m, t);
	endtask

	// mostly a clock that moves forward with buttons mixed in; some noise
	task automatic send_random_word();
		int          r;
		logic [31:0] t;
		r = $urandom_range(99);
		t = $urandom();
		if (r < 55) begin
			if ($urandom_range(9) == 0)
				clock_ms = $urandom();
			else
				clock_ms = clock_ms + $urandom_range(250000);
			send_word(lsw_pkg::MODE_TIME, clock_ms);
		end else if (r < 76) begin
			send_word(lsw_pkg::MODE_PRIMARY, t);
		end else if (r < 94) begin
			send_word(lsw_pkg::MODE_SECONDARY, t);
		end else begin
			send_word(MODE_UNUSED, t);
		end
	endtask

	task automatic run_random(input int n);
		repeat (n) send_random_word();
	endtask

	// hold the input until every pending view has come out
	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (tracker.pending_views.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// Output side: sample results at the edge, then pick the next ready
	initial begin
		watch_view_t seen;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				seen.run_state    = run_state;
				seen.elapsed_ms   = elapsed_ms;
				seen.minutes      = minutes;
				seen.seconds      = seconds;
				seen.centiseconds = centiseconds;
				seen.laps_shown   = laps_shown;
				seen.lap_ms       = {lap2_ms, lap1_ms, lap0_ms};
				seen.lap_num      = {lap2_number, lap1_number, lap0_number};
				tracker.match_view(seen);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Stimulus
	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		mode     <= lsw_pkg::MODE_TIME;
		now_ms   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored presses, wrap of the running interval, lap
		// saturation, stop/resume, full reset, largest elapsed time
		send_word(lsw_pkg::MODE_SECONDARY, 32'h0000_0000);
		send_word(MODE_UNUSED,             32'hFFFF_FFFF);
		send_word(lsw_pkg::MODE_TIME,      32'hFFFF_FF00);
		send_word(lsw_pkg::MODE_PRIMARY,   32'h5555_5555);
		send_word(lsw_pkg::MODE_TIME,      32'h0000_1234);
		send_word(lsw_pkg::MODE_PRIMARY,   32'h0000_0000);
		send_word(lsw_pkg::MODE_TIME,      32'hFFFF_FFFF);
		send_word(lsw_pkg::MODE_PRIMARY,   32'hAAAA_AAAA);
		send_word(MODE_UNUSED,             32'h0000_0001);
		send_word(lsw_pkg::MODE_TIME,      32'h0001_0000);
		send_word(lsw_pkg::MODE_PRIMARY,   32'h0000_0000);
		send_word(lsw_pkg::MODE_PRIMARY,   32'h0000_0000);
		send_word(lsw_pkg::MODE_SECONDARY, 32'h0000_0000);
		send_word(MODE_UNUSED,             32'h8000_0000);
		send_word(lsw_pkg::MODE_TIME,      32'h0000_0000);
		send_word(lsw_pkg::MODE_SECONDARY, 32'h0000_0000);
		send_word(lsw_pkg::MODE_TIME,      32'h7FFF_FFFF);
		send_word(lsw_pkg::MODE_SECONDARY, 32'h0000_0000);
		send_word(lsw_pkg::MODE_PRIMARY,   32'h0000_0000);
		send_word(lsw_pkg::MODE_PRIMARY,   32'h0000_0000);
		send_word(lsw_pkg::MODE_TIME,      32'hFFFF_FFFF);
		send_word(lsw_pkg::MODE_SECONDARY, 32'h0000_0000);
		send_word(lsw_pkg::MODE_PRIMARY,   32'h0000_0000);
		drain();

		// sender mostly busy, receiver mostly stalled
		run_random(500);

		// long output stall while words keep coming, so the pipe backs up
		send_idle_pct = 0;
		hold_left     = 300;
		run_random(80);
		drain();

		// sender mostly idle, receiver mostly ready
		send_idle_pct = 84;
		recv_idle_pct = 23;
		run_random(470);
		drain();

		// no gaps on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(480);

		// back to idle, then one short start, stop and full reset
		if (tracker.phase == lsw_pkg::RS_RUN)
			send_word(lsw_pkg::MODE_SECONDARY, '0);
		if (tracker.phase == lsw_pkg::RS_STOP)
			send_word(lsw_pkg::MODE_PRIMARY, '0);
		send_word(lsw_pkg::MODE_PRIMARY, '0);
		send_word(lsw_pkg::MODE_SECONDARY, '0);
		send_word(lsw_pkg::MODE_PRIMARY, '0);

		drain();
		repeat (20) @(posedge clk);

		$display("Run covered %0d words and %0d checked results over three stall mixes,",
			tracker.words, tracker.views_checked);
		$display("a long output stall that backed up the pipe, and full drains between.");
		if (tracker.pending_views.size() != 0)
			$display("%0d expected results never arrived", tracker.pending_views.size());
		if (tracker.mismatches == 0 && tracker.pending_views.size() == 0) begin
			$display("lap_stopwatch_core verification clean");
		end else begin
			$display("lap_stopwatch_core verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("lap_stopwatch_core verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/lsw_pkg.sv
hw/rtl/lsw_state.sv
hw/rtl/lap_stopwatch_core.sv
tb/tb_top.sv
